/* sv/mhp_pkg.sv */
// Shared types, constants and the sequencer program for the binary max-heap.
// Used by the channel interfaces, the sequencer and the top level; it depends on nothing.
package mhp_pkg;

    // Fixed field widths of the request and response items.
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;
    localparam int SLOT_W   = 4;

    // Default heap capacity (legal range 2 to 16).
    localparam int CAPACITY_DEF = 16;

    // Width of the sequencer step counter.
    localparam int STEP_W = 5;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } t_status;

    // Branch conditions. A step jumps to its target and performs its
    // operation when the condition holds; otherwise it falls through.
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_START,
        C_IS_DEL,
        C_NOT_FULL,
        C_POS_AT_CNT,
        C_NO_MATCH,
        C_LEFT_OUT,
        C_RIGHT_OUT,
        C_BEST_SELF,
        C_POS_ZERO,
        C_LESS,
        C_OUT_BUSY
    } t_cond;

    // Memory read address select.
    typedef enum logic [2:0] {
        RS_NONE,
        RS_POS,
        RS_LAST,
        RS_LEFT,
        RS_RIGHT,
        RS_PARENT,
        RS_ROOT
    } t_rsel;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_POS_CLR,
        OP_INS_START,
        OP_ST_FULL,
        OP_POS_INC,
        OP_FOUND,
        OP_TAKE_X,
        OP_BEST_LEFT,
        OP_BEST_RIGHT,
        OP_SINK_MOVE,
        OP_LIFT_MOVE,
        OP_WRITE_X,
        OP_ST_MISS,
        OP_POST
    } t_op;

    // One control word of the program.
    typedef struct packed {
        t_cond             cond;
        logic [STEP_W-1:0] target;
        t_rsel             rsel;
        t_op               op;
    } t_ctrl;

    // Condition flags reported by the datapath.
    typedef struct packed {
        logic no_start;
        logic is_del;
        logic not_full;
        logic pos_at_cnt;
        logic no_match;
        logic left_out;
        logic right_out;
        logic best_self;
        logic pos_zero;
        logic less;
        logic out_busy;
    } t_flags;

    // Sequencer outputs to the datapath.
    typedef struct packed {
        t_ctrl ctrl;
        logic  take;
        logic  idle;
    } t_seq;

    // Program step addresses.
    localparam logic [STEP_W-1:0] S_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH  = 5'd1;
    localparam logic [STEP_W-1:0] S_INS       = 5'd2;
    localparam logic [STEP_W-1:0] S_FULL      = 5'd3;
    localparam logic [STEP_W-1:0] S_SRCH_RD   = 5'd4;
    localparam logic [STEP_W-1:0] S_SRCH_CMP  = 5'd5;
    localparam logic [STEP_W-1:0] S_FOUND     = 5'd6;
    localparam logic [STEP_W-1:0] S_TAKE      = 5'd7;
    localparam logic [STEP_W-1:0] S_SINK_L    = 5'd8;
    localparam logic [STEP_W-1:0] S_SINK_LCMP = 5'd9;
    localparam logic [STEP_W-1:0] S_SINK_R    = 5'd10;
    localparam logic [STEP_W-1:0] S_SINK_RCMP = 5'd11;
    localparam logic [STEP_W-1:0] S_SINK_CHK  = 5'd12;
    localparam logic [STEP_W-1:0] S_SINK_MOVE = 5'd13;
    localparam logic [STEP_W-1:0] S_LIFT_RD   = 5'd14;
    localparam logic [STEP_W-1:0] S_LIFT_CMP  = 5'd15;
    localparam logic [STEP_W-1:0] S_PLACE     = 5'd16;
    localparam logic [STEP_W-1:0] S_MISS      = 5'd17;
    localparam logic [STEP_W-1:0] S_ROOT_RD   = 5'd18;
    localparam logic [STEP_W-1:0] S_WAIT_OUT  = 5'd19;
    localparam logic [STEP_W-1:0] S_POST      = 5'd20;

    // The control program, one word per step.
    function automatic t_ctrl prog_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        case (step)
            // Wait for a request, then branch on its action.
            S_IDLE:      w = '{C_NO_START,   S_IDLE,      RS_NONE,   OP_NONE};
            S_DISPATCH:  w = '{C_IS_DEL,     S_SRCH_RD,   RS_NONE,   OP_POS_CLR};
            // Insert: open a hole at the end and lift it.
            S_INS:       w = '{C_NOT_FULL,   S_LIFT_RD,   RS_NONE,   OP_INS_START};
            S_FULL:      w = '{C_ALWAYS,     S_ROOT_RD,   RS_NONE,   OP_ST_FULL};
            // Delete: linear search from the root slot.
            S_SRCH_RD:   w = '{C_POS_AT_CNT, S_MISS,      RS_POS,    OP_NONE};
            S_SRCH_CMP:  w = '{C_NO_MATCH,   S_SRCH_RD,   RS_NONE,   OP_POS_INC};
            S_FOUND:     w = '{C_ALWAYS,     S_TAKE,      RS_LAST,   OP_FOUND};
            S_TAKE:      w = '{C_ALWAYS,     S_SINK_L,    RS_NONE,   OP_TAKE_X};
            // Sink the moved entry.
            S_SINK_L:    w = '{C_LEFT_OUT,   S_LIFT_RD,   RS_LEFT,   OP_NONE};
            S_SINK_LCMP: w = '{C_ALWAYS,     S_SINK_R,    RS_NONE,   OP_BEST_LEFT};
            S_SINK_R:    w = '{C_RIGHT_OUT,  S_SINK_CHK,  RS_RIGHT,  OP_NONE};
            S_SINK_RCMP: w = '{C_ALWAYS,     S_SINK_CHK,  RS_NONE,   OP_BEST_RIGHT};
            S_SINK_CHK:  w = '{C_BEST_SELF,  S_LIFT_RD,   RS_NONE,   OP_NONE};
            S_SINK_MOVE: w = '{C_ALWAYS,     S_SINK_L,    RS_NONE,   OP_SINK_MOVE};
            // Lift the hole toward the root.
            S_LIFT_RD:   w = '{C_POS_ZERO,   S_PLACE,     RS_PARENT, OP_NONE};
            S_LIFT_CMP:  w = '{C_LESS,       S_LIFT_RD,   RS_NONE,   OP_LIFT_MOVE};
            S_PLACE:     w = '{C_ALWAYS,     S_ROOT_RD,   RS_NONE,   OP_WRITE_X};
            S_MISS:      w = '{C_ALWAYS,     S_ROOT_RD,   RS_NONE,   OP_ST_MISS};
            // Read the root and post the response.
            S_ROOT_RD:   w = '{C_ALWAYS,     S_WAIT_OUT,  RS_ROOT,   OP_NONE};
            S_WAIT_OUT:  w = '{C_OUT_BUSY,   S_WAIT_OUT,  RS_NONE,   OP_NONE};
            S_POST:      w = '{C_ALWAYS,     S_IDLE,      RS_NONE,   OP_POST};
            default:     w = '{C_ALWAYS,     S_IDLE,      RS_NONE,   OP_NONE};
        endcase
        return w;
    endfunction

endpackage

/* sv/mhp_req_if.sv */
// Request channel of the max-heap: valid/ready handshake with action and value.
// Depends on mhp_pkg for the data width.
interface mhp_req_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic signed [mhp_pkg::DATA_W-1:0] value;

    modport source(output valid, output action, output value, input ready);
    modport sink(input valid, input action, input value, output ready);
endinterface

/* sv/mhp_rsp_if.sv */
// Response channel of the max-heap: valid/ready handshake with the result fields.
// Depends on mhp_pkg for the field widths.
interface mhp_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [mhp_pkg::STATUS_W-1:0]        status;
    logic [mhp_pkg::TOTAL_W-1:0]         entry_total;
    logic signed [mhp_pkg::DATA_W-1:0]   top_value;
    logic [mhp_pkg::SLOT_W-1:0]          found_slot;

    modport source(output valid, output status, output entry_total, output top_value,
                   output found_slot, input ready);
    modport sink(input valid, input status, input entry_total, input top_value,
                 input found_slot, output ready);
endinterface

/* sv/mhp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module mhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mhp_seq.sv */
// Microcode sequencer of the max-heap: step counter, program table and branch logic.
// Depends on mhp_pkg for the control word, flag and step types.
module mhp_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mhp_pkg::t_flags i_flags,
    output mhp_pkg::t_seq   o_seq
);

    logic [mhp_pkg::STEP_W-1:0] r_step;
    logic [mhp_pkg::STEP_W-1:0] n_step;
    mhp_pkg::t_ctrl             w_ctrl;
    logic                       w_take;

    // Fetch the control word of the current step.
    assign w_ctrl = mhp_pkg::prog_word(r_step);

    // Evaluate the branch condition of this step.
    always_comb begin
        case (w_ctrl.cond)
            mhp_pkg::C_ALWAYS:     w_take = 1'b1;
            mhp_pkg::C_NO_START:   w_take = i_flags.no_start;
            mhp_pkg::C_IS_DEL:     w_take = i_flags.is_del;
            mhp_pkg::C_NOT_FULL:   w_take = i_flags.not_full;
            mhp_pkg::C_POS_AT_CNT: w_take = i_flags.pos_at_cnt;
            mhp_pkg::C_NO_MATCH:   w_take = i_flags.no_match;
            mhp_pkg::C_LEFT_OUT:   w_take = i_flags.left_out;
            mhp_pkg::C_RIGHT_OUT:  w_take = i_flags.right_out;
            mhp_pkg::C_BEST_SELF:  w_take = i_flags.best_self;
            mhp_pkg::C_POS_ZERO:   w_take = i_flags.pos_zero;
            mhp_pkg::C_LESS:       w_take = i_flags.less;
            mhp_pkg::C_OUT_BUSY:   w_take = i_flags.out_busy;
            default:               w_take = 1'b0;
        endcase
    end

    // Jump to the target on a taken branch, otherwise step forward.
    always_comb begin
        if (w_take) begin
            n_step = w_ctrl.target;
        end else begin
            n_step = r_step + mhp_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mhp_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_seq.ctrl = w_ctrl;
    assign o_seq.take = w_take;
    assign o_seq.idle = (r_step == mhp_pkg::S_IDLE);

endmodule

/* sv/max_heap_insert_delete.sv */
// Binary max-heap of signed 32-bit values with insert and delete-by-value.
// Channels: i_req (sink) carries action (0 insert, 1 delete) and value; o_rsp
// (source) carries status, entry_total, top_value and found_slot. Each channel
// is a valid/ready pair and a transfer happens on a clock edge where both are
// high. Every request gives exactly one response.
// A small microcoded sequencer drives one heap RAM with one read and one write
// port; every memory access is one step, so latency follows the tree walk.
// The next request is taken in the wait step after a post. The response sits in an
// output register: a stalled receiver does not block the next request, only the
// posting of the one after it.
// Reset (i_rst_n low, synchronous) empties the heap and drops any pending
// response; the heap RAM itself is not cleared.
// Depends on mhp_pkg, mhp_req_if, mhp_rsp_if, mhp_ram and mhp_seq.
module max_heap_insert_delete #(
    parameter int CAPACITY = mhp_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhp_req_if.sink    i_req,
    mhp_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(CAPACITY);       // slot index width
    localparam int CW = $clog2(CAPACITY + 1);   // entry count width
    localparam int KW = IW + 2;                 // width for child arithmetic
    localparam int DW = mhp_pkg::DATA_W;

    // Sequencer link.
    mhp_pkg::t_flags w_flags;
    mhp_pkg::t_seq   w_seq;
    mhp_pkg::t_op    w_op;

    // Datapath registers.
    logic signed [DW-1:0] r_x,        n_x;
    logic                 r_act,      n_act;
    logic [KW-1:0]        r_pos,      n_pos;
    logic [CW-1:0]        r_cnt,      n_cnt;
    logic signed [DW-1:0] r_best_val, n_best_val;
    logic [KW-1:0]        r_best_idx, n_best_idx;
    logic [IW-1:0]        r_slot,     n_slot;
    mhp_pkg::t_status     r_status,   n_status;

    // Output register.
    logic                            r_out_valid, n_out_valid;
    logic [mhp_pkg::STATUS_W-1:0]    r_o_status,  n_o_status;
    logic [mhp_pkg::TOTAL_W-1:0]     r_o_total,   n_o_total;
    logic signed [DW-1:0]            r_o_top,     n_o_top;
    logic [mhp_pkg::SLOT_W-1:0]      r_o_slot,    n_o_slot;

    // Address arithmetic and memory signals.
    logic [KW-1:0]        w_cnt_k;
    logic [KW-1:0]        w_left;
    logic [KW-1:0]        w_right;
    logic [KW-1:0]        w_pos_m1;
    logic [KW-1:0]        w_parent;
    logic [KW-1:0]        w_raddr_k;
    logic [DW-1:0]        w_rdata;
    logic signed [DW-1:0] w_rd;
    logic                 w_re;
    logic                 w_we;
    logic [DW-1:0]        w_wdata;
    logic                 w_in_xfer;
    logic                 w_out_xfer;
    logic [CW+mhp_pkg::TOTAL_W-1:0] w_total_ext;
    logic [IW+mhp_pkg::SLOT_W-1:0]  w_slot_ext;

    assign w_in_xfer  = i_req.valid && i_req.ready;
    assign w_out_xfer = r_out_valid && o_rsp.ready;
    assign w_op       = w_seq.take ? w_seq.ctrl.op : mhp_pkg::OP_NONE;

    // Tree index arithmetic.
    assign w_cnt_k  = {{(KW - CW){1'b0}}, r_cnt};
    assign w_left   = {1'b0, r_pos[IW-1:0], 1'b1};
    assign w_right  = {1'b0, r_pos[IW-1:0], 1'b0} + KW'(2);
    assign w_pos_m1 = r_pos - KW'(1);
    assign w_parent = {1'b0, w_pos_m1[KW-1:1]};
    assign w_rd     = $signed(w_rdata);

    // Read address select.
    always_comb begin
        case (w_seq.ctrl.rsel)
            mhp_pkg::RS_POS:    w_raddr_k = r_pos;
            mhp_pkg::RS_LAST:   w_raddr_k = w_cnt_k - KW'(1);
            mhp_pkg::RS_LEFT:   w_raddr_k = w_left;
            mhp_pkg::RS_RIGHT:  w_raddr_k = w_right;
            mhp_pkg::RS_PARENT: w_raddr_k = w_parent;
            default:            w_raddr_k = '0;
        endcase
    end
    assign w_re = (w_seq.ctrl.rsel != mhp_pkg::RS_NONE);

    // Write port: every write lands at the current hole position.
    always_comb begin
        case (w_op)
            mhp_pkg::OP_SINK_MOVE: w_wdata = r_best_val;
            mhp_pkg::OP_LIFT_MOVE: w_wdata = w_rdata;
            default:               w_wdata = r_x;
        endcase
    end
    assign w_we = (w_op == mhp_pkg::OP_SINK_MOVE) || (w_op == mhp_pkg::OP_LIFT_MOVE) ||
                  (w_op == mhp_pkg::OP_WRITE_X);

    mhp_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos[IW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr_k[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // Condition flags for the sequencer.
    always_comb begin
        w_flags.no_start   = !i_req.valid;
        w_flags.is_del     = r_act;
        w_flags.not_full   = (r_cnt != CW'(CAPACITY));
        w_flags.pos_at_cnt = (r_pos == w_cnt_k);
        w_flags.no_match   = (w_rd != r_x);
        w_flags.left_out   = (w_left >= w_cnt_k);
        w_flags.right_out  = (w_right >= w_cnt_k);
        w_flags.best_self  = (r_best_idx == r_pos);
        w_flags.pos_zero   = (r_pos == '0);
        w_flags.less       = (w_rd < r_x);
        w_flags.out_busy   = r_out_valid && !o_rsp.ready;
    end

    mhp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_seq   (w_seq)
    );

    // Response field formatting.
    assign w_total_ext = {{mhp_pkg::TOTAL_W{1'b0}}, r_cnt};
    assign w_slot_ext  = {{mhp_pkg::SLOT_W{1'b0}}, r_slot};

    // Datapath next-state logic.
    always_comb begin
        n_x         = r_x;
        n_act       = r_act;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_slot      = r_slot;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_total   = r_o_total;
        n_o_top     = r_o_top;
        n_o_slot    = r_o_slot;

        // Capture a new request.
        if (w_in_xfer) begin
            n_x      = i_req.value;
            n_act    = i_req.action;
            n_slot   = '0;
            n_status = mhp_pkg::STAT_DONE;
        end

        // The receiver took the pending response.
        if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (w_op)
            mhp_pkg::OP_POS_CLR: begin
                n_pos = '0;
            end
            mhp_pkg::OP_INS_START: begin
                n_pos = w_cnt_k;
                n_cnt = r_cnt + CW'(1);
            end
            mhp_pkg::OP_ST_FULL: begin
                n_status = mhp_pkg::STAT_FULL;
            end
            mhp_pkg::OP_POS_INC: begin
                n_pos = r_pos + KW'(1);
            end
            mhp_pkg::OP_FOUND: begin
                n_slot = r_pos[IW-1:0];
                n_cnt  = r_cnt - CW'(1);
            end
            mhp_pkg::OP_TAKE_X: begin
                n_x = w_rd;
            end
            mhp_pkg::OP_BEST_LEFT: begin
                if (r_x < w_rd) begin
                    n_best_val = w_rd;
                    n_best_idx = w_left;
                end else begin
                    n_best_val = r_x;
                    n_best_idx = r_pos;
                end
            end
            mhp_pkg::OP_BEST_RIGHT: begin
                if (r_best_val < w_rd) begin
                    n_best_val = w_rd;
                    n_best_idx = w_right;
                end
            end
            mhp_pkg::OP_SINK_MOVE: begin
                n_pos = r_best_idx;
            end
            mhp_pkg::OP_LIFT_MOVE: begin
                n_pos = w_parent;
            end
            mhp_pkg::OP_ST_MISS: begin
                n_status = mhp_pkg::STAT_MISS;
            end
            mhp_pkg::OP_POST: begin
                n_out_valid = 1'b1;
                n_o_status  = r_status;
                n_o_total   = w_total_ext[mhp_pkg::TOTAL_W-1:0];
                n_o_top     = (r_cnt == '0) ? '0 : w_rd;
                n_o_slot    = w_slot_ext[mhp_pkg::SLOT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_act      <= n_act;
        r_pos      <= n_pos;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_total  <= n_o_total;
        r_o_top    <= n_o_top;
        r_o_slot   <= n_o_slot;
    end

    // Ports.
    assign i_req.ready       = w_seq.idle;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.entry_total = r_o_total;
    assign o_rsp.top_value   = r_o_top;
    assign o_rsp.found_slot  = r_o_slot;

`ifndef SYNTHESIS
    // The entry count never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("heap entry count above capacity");

    // Heap writes always target a slot inside the store.
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_pos < KW'(CAPACITY)))
        else $error("heap write outside the store");

    // Posting a response makes it visible on the next cycle.
    a_post_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == mhp_pkg::OP_POST) |=> r_out_valid)
        else $error("posted response not valid");

    // A posted response never overwrites one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == mhp_pkg::OP_POST) |-> (!r_out_valid || o_rsp.ready))
        else $error("pending response overwritten");

    // Once a request is taken the sequencer leaves its wait step.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !w_seq.idle)
        else $error("sequencer stayed idle after a request");
`endif

endmodule

/* bench/max_heap_insert_delete_test.sv */
// Self-checking bench for the binary max-heap: directed corner requests, then random phases.
// Depends on mhp_pkg, mhp_req_if, mhp_rsp_if and the max_heap_insert_delete top level.
module max_heap_insert_delete_test;

    localparam int HEAP_DEPTH  = mhp_pkg::CAPACITY_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 150;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 78;
    localparam int DIRECTED_N  = 26;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    localparam logic signed [mhp_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [mhp_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // One response item as the bench sees it.
    typedef struct packed {
        logic [mhp_pkg::STATUS_W-1:0]        status;
        logic [mhp_pkg::TOTAL_W-1:0]         total;
        logic signed [mhp_pkg::DATA_W-1:0]   top;
        logic [mhp_pkg::SLOT_W-1:0]          slot;
    } t_heap_rsp;

    // One directed request; the response is typed in only where fixed is set.
    typedef struct packed {
        logic                                act;
        logic signed [mhp_pkg::DATA_W-1:0]   val;
        logic                                fixed;
        t_heap_rsp                           rsp;
    } t_heap_row;

    logic i_clk;
    logic i_rst_n;

    mhp_req_if req_ch();
    mhp_rsp_if rsp_ch();

    max_heap_insert_delete dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Directed requests: empty heap, extremes, duplicates, a full heap and a miss.
    t_heap_row directed_rows [0:DIRECTED_N-1] = '{
        '{ACT_DELETE, 32'sd5,     1'b1, '{mhp_pkg::STAT_MISS, 5'd0,  32'sd0,  4'd0}},
        '{ACT_INSERT, VAL_MIN,    1'b1, '{mhp_pkg::STAT_DONE, 5'd1,  VAL_MIN, 4'd0}},
        '{ACT_INSERT, VAL_MAX,    1'b1, '{mhp_pkg::STAT_DONE, 5'd2,  VAL_MAX, 4'd0}},
        '{ACT_DELETE, VAL_MAX,    1'b1, '{mhp_pkg::STAT_DONE, 5'd1,  VAL_MIN, 4'd0}},
        '{ACT_DELETE, VAL_MIN,    1'b1, '{mhp_pkg::STAT_DONE, 5'd0,  32'sd0,  4'd0}},
        '{ACT_INSERT, 32'sd0,     1'b1, '{mhp_pkg::STAT_DONE, 5'd1,  32'sd0,  4'd0}},
        '{ACT_INSERT, -32'sd1,    1'b1, '{mhp_pkg::STAT_DONE, 5'd2,  32'sd0,  4'd0}},
        '{ACT_DELETE, -32'sd1,    1'b1, '{mhp_pkg::STAT_DONE, 5'd1,  32'sd0,  4'd1}},
        '{ACT_INSERT, 32'sd7,     1'b0, '0},
        '{ACT_INSERT, 32'sd7,     1'b0, '0},
        '{ACT_INSERT, 32'sd3,     1'b0, '0},
        '{ACT_INSERT, -32'sd20,   1'b0, '0},
        '{ACT_INSERT, 32'sd12,    1'b0, '0},
        '{ACT_INSERT, 32'sd7,     1'b0, '0},
        '{ACT_INSERT, 32'sd40,    1'b0, '0},
        '{ACT_INSERT, -32'sd5,    1'b0, '0},
        '{ACT_INSERT, 32'sd100,   1'b0, '0},
        '{ACT_INSERT, 32'sd65535, 1'b0, '0},
        '{ACT_INSERT, -32'sd100,  1'b0, '0},
        '{ACT_INSERT, 32'sd1,     1'b0, '0},
        '{ACT_INSERT, 32'sd2,     1'b0, '0},
        '{ACT_INSERT, 32'sd55,    1'b0, '0},
        '{ACT_INSERT, 32'sd7,     1'b0, '0},
        '{ACT_INSERT, 32'sd8,     1'b1, '{mhp_pkg::STAT_FULL, 5'd16, 32'sd65535, 4'd0}},
        '{ACT_DELETE, 32'sd7,     1'b0, '0},
        '{ACT_DELETE, 32'sd999,   1'b1, '{mhp_pkg::STAT_MISS, 5'd15, 32'sd65535, 4'd0}}
    };

    // Insert share, in percent, of each random phase.
    int phase_ins_pct [0:PHASES-1] = '{85, 50, 20, 70, 30, 90, 50, 15};

    // Predictor state.
    logic signed [mhp_pkg::DATA_W-1:0] heap_model [0:HEAP_DEPTH-1];
    int                                heap_fill;

    // Responses due, oldest first.
    t_heap_rsp heap_rsp_due [$];

    // Values the sender has put in and not yet taken out, used to aim deletes.
    logic signed [mhp_pkg::DATA_W-1:0] held_values [$];

    // Side information that travels with each request.
    logic      req_has_fixed;
    t_heap_rsp req_fixed_rsp;

    bit send_idle_on;
    bit recv_idle_on;
    bit hold_request;

    int fail_count;
    int quiet_cycles;
    int ins_taken;
    int del_taken;
    int full_drops;
    int del_misses;
    int deepest_fill;
    int holds_done;
    int drain_pauses;

    // Apply one request to the predictor and return the response it must give.
    function automatic t_heap_rsp apply_heap_request(
        input logic act,
        input logic signed [mhp_pkg::DATA_W-1:0] val);
        t_heap_rsp                         r;
        int                                n;
        int                                p;
        int                                lc;
        int                                rc;
        int                                best;
        int                                up;
        logic signed [mhp_pkg::DATA_W-1:0] t;

        r.status = mhp_pkg::STAT_DONE;
        r.slot   = '0;
        if (act == ACT_INSERT) begin
            if (heap_fill < HEAP_DEPTH) begin
                // Open a hole at the end and move it up past smaller parents.
                n = heap_fill;
                while (n > 0 && heap_model[(n - 1) / 2] < val) begin
                    heap_model[n] = heap_model[(n - 1) / 2];
                    n = (n - 1) / 2;
                end
                heap_model[n] = val;
                heap_fill++;
            end else begin
                r.status = mhp_pkg::STAT_FULL;
            end
        end else begin
            p = 0;
            while (p < heap_fill && heap_model[p] != val)
                p++;
            if (p < heap_fill) begin
                r.slot        = p[mhp_pkg::SLOT_W-1:0];
                heap_model[p] = heap_model[heap_fill - 1];
                heap_fill--;
                // Sink the moved entry, left child checked first.
                while (p < heap_fill) begin
                    lc   = 2 * p + 1;
                    rc   = 2 * p + 2;
                    best = p;
                    if (lc < heap_fill && heap_model[best] < heap_model[lc])
                        best = lc;
                    if (rc < heap_fill && heap_model[best] < heap_model[rc])
                        best = rc;
                    if (best == p)
                        break;
                    t                = heap_model[p];
                    heap_model[p]    = heap_model[best];
                    heap_model[best] = t;
                    p                = best;
                end
                // Then lift it while it beats its parent.
                while (p > 0 && p < heap_fill) begin
                    up = (p - 1) / 2;
                    if (!(heap_model[up] < heap_model[p]))
                        break;
                    t              = heap_model[p];
                    heap_model[p]  = heap_model[up];
                    heap_model[up] = t;
                    p              = up;
                end
            end else begin
                r.status = mhp_pkg::STAT_MISS;
            end
        end
        r.total = heap_fill[mhp_pkg::TOTAL_W-1:0];
        r.top   = (heap_fill > 0) ? heap_model[0] : '0;
        return r;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", what);
    endtask

    // Offer one request, after a random gap when send idles are on, and return at the edge of its transfer.
    task automatic push_request(input logic act,
                                input logic signed [mhp_pkg::DATA_W-1:0] val,
                                input logic fixed, input t_heap_rsp fixed_rsp);
        int gap;
        int k;

        gap = send_idle_on ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= val;
        req_has_fixed <= fixed;
        req_fixed_rsp <= fixed_rsp;
        do @(posedge i_clk); while (!req_ch.ready);

        // Keep the list of live values in step with what was sent.
        if (act == ACT_INSERT) begin
            if (held_values.size() < HEAP_DEPTH)
                held_values.push_back(val);
        end else begin
            for (k = 0; k < held_values.size(); k++) begin
                if (held_values[k] == val) begin
                    held_values.delete(k);
                    break;
                end
            end
        end
    endtask

    // Drop valid and wait until every response due has come back.
    task automatic drain_heap;
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (heap_rsp_due.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check each response transfer and predict each request transfer.
    always @(posedge i_clk) begin
        t_heap_rsp got_rsp;
        t_heap_rsp want_rsp;
        t_heap_rsp pred_rsp;

        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got_rsp = '{rsp_ch.status, rsp_ch.entry_total, rsp_ch.top_value,
                            rsp_ch.found_slot};
                if (heap_rsp_due.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected response: status %0d total %0d top %0d slot %0d",
                        got_rsp.status, got_rsp.total, got_rsp.top, got_rsp.slot));
                end else begin
                    want_rsp = heap_rsp_due.pop_front();
                    if (got_rsp.status !== want_rsp.status ||
                        got_rsp.total !== want_rsp.total ||
                        got_rsp.top !== want_rsp.top || got_rsp.slot !== want_rsp.slot)
                        note_failure($sformatf({"response mismatch: expected status %0d ",
                                                "total %0d top %0d slot %0d, got status %0d ",
                                                "total %0d top %0d slot %0d"},
                                               want_rsp.status, want_rsp.total, want_rsp.top,
                                               want_rsp.slot, got_rsp.status, got_rsp.total,
                                               got_rsp.top, got_rsp.slot));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                pred_rsp = apply_heap_request(req_ch.action, req_ch.value);
                heap_rsp_due.push_back(req_has_fixed ? req_fixed_rsp : pred_rsp);
                if (req_ch.action == ACT_INSERT)
                    ins_taken++;
                else
                    del_taken++;
                if (pred_rsp.status == mhp_pkg::STAT_FULL)
                    full_drops++;
                if (pred_rsp.status == mhp_pkg::STAT_MISS)
                    del_misses++;
                if (heap_fill > deepest_fill)
                    deepest_fill = heap_fill;
            end
        end
    end

    // End the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d responses due",
                     quiet_cycles, heap_rsp_due.size());
            $display("[max_heap_insert_delete] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls per response when enabled, plus one long hold-off when asked.
    initial begin
        int wait_cycles;

        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                wait_cycles  = HOLD_CYCLES;
                hold_request = 1'b0;
                holds_done++;
            end else begin
                wait_cycles = recv_idle_on ? $urandom_range(0, 12) : 0;
            end
            if (wait_cycles != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // Sender: reset, directed table, then random phases.
    initial begin
        int                                k;
        int                                phase;
        int                                pick;
        logic                              act;
        logic signed [mhp_pkg::DATA_W-1:0] val;

        i_rst_n       <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_INSERT;
        req_ch.value  <= '0;
        req_has_fixed <= 1'b0;
        req_fixed_rsp <= '0;
        heap_fill     = 0;
        send_idle_on  = 1'b1;
        recv_idle_on  = 1'b1;
        hold_request  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIRECTED_N; k++)
            push_request(directed_rows[k].act, directed_rows[k].val, directed_rows[k].fixed,
                         directed_rows[k].rsp);

        for (phase = 0; phase < PHASES; phase++) begin
            drain_heap();
            drain_pauses++;
            send_idle_on = (phase % 2) == 0;
            recv_idle_on = (phase % 4) < 2;
            // With the block idle, ask the receiver for a long hold-off.
            if (phase == 2)
                hold_request = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                act  = ($urandom_range(0, 99) < phase_ins_pct[phase]) ? ACT_INSERT : ACT_DELETE;
                pick = $urandom_range(0, 9);
                if (act == ACT_DELETE && held_values.size() != 0 && pick < 8)
                    val = held_values[$urandom_range(0, held_values.size() - 1)];
                else if (pick < 4)
                    val = $urandom_range(0, 30) - 15;
                else if (pick < 8)
                    val = $urandom;
                else begin
                    case ($urandom_range(0, 3))
                        0: val = VAL_MIN;
                        1: val = VAL_MAX;
                        2: val = '0;
                        default: val = -32'sd1;
                    endcase
                end
                push_request(act, val, 1'b0, '0);
            end
        end

        drain_heap();
        repeat (SETTLE) @(posedge i_clk);

        $display("Ran %0d inserts and %0d deletes; %0d dropped on a full heap, %0d deletes missed.",
                 ins_taken, del_taken, full_drops, del_misses);
        $display("Deepest fill %0d entries, %0d long receiver hold-off(s), %0d drain pauses.",
                 deepest_fill, holds_done, drain_pauses);
        if (fail_count == 0) begin
            $display("[max_heap_insert_delete] OK");
        end else begin
            $display("%0d failures in total", fail_count);
            $display("[max_heap_insert_delete] ERROR");
        end
        $finish;
    end

endmodule
